@@ design/swfrm_pkg.sv @@
package swfrm_pkg;

  // Field widths
  localparam int unsigned IDX_W    = 31;
  localparam int unsigned TS_W     = 48;
  localparam int unsigned WIN_W    = 26;
  localparam int unsigned FPS_W    = 9;
  localparam int unsigned AVG_W    = 17;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SUM_W    = 25;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // Mean divider: dividend is the sum shifted up by 8 (Q8)
  localparam int unsigned DVD_W    = SUM_W + 8;
  localparam int unsigned DSR_W    = CNT_W;

  // Saturation limits and reset values
  localparam logic [FPS_W-1:0] FPS_MAX      = '1;
  localparam logic [SUM_W-1:0] SUM_MAX      = '1;
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam logic [AVG_W-1:0] AVG_MAX      = '1;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000000);

  // Command and result kinds
  localparam logic CMD_FRAME   = 1'b0;
  localparam logic CMD_REPORT  = 1'b1;
  localparam logic KIND_RATE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Register map (word index, taken from paddr[2])
  localparam logic REG_WINDOW = 1'b0;

  typedef struct packed {
    logic            cmd;
    logic [IDX_W-1:0] frame_index;
    logic [TS_W-1:0]  timestamp_us;
  } in_word_t;

  typedef struct packed {
    logic             kind;
    logic [FPS_W-1:0] fps;
    logic [IDX_W-1:0] frame_echo;
    logic [AVG_W-1:0] avg_fps_q8;
    logic [FPS_W-1:0] min_fps;
    logic [FPS_W-1:0] max_fps;
    logic [CNT_W-1:0] batch_count;
    logic             empty_res;
  } out_word_t;

endpackage

@@ design/swfrm_ram.sv @@
module swfrm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/swfrm_div.sv @@
module swfrm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [swfrm_pkg::DVD_W-1:0]   dividend_i,
  input  logic [swfrm_pkg::DSR_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [swfrm_pkg::DVD_W-1:0]   quotient_o
);
  import swfrm_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DSR_W:0]   rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DSR_W:0]   rem_sh;
  logic             ge;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[DSR_W-1:0], quo_q[DVD_W-1]};
    ge     = (rem_sh >= {1'b0, dsr_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CW'(DVD_W);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ design/sliding_window_frame_rate_meter.sv @@
// Frame word: the timestamp is written to the ring, then the ring scan loop retires expired
// entries one per cycle, fed by the ring memory's registered read port.
// Report word: the result waits for the 33-step mean divider, which is skipped if the batch is empty.
// One word is in flight at a time; the next is taken the cycle after the result
// is loaded, while that result may still wait in the output register.
// Reset clears pointers, occupancy, last index and statistics, restores the window default; ring data is not cleared.
module sliding_window_frame_rate_meter #(
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  swfrm_pkg::in_word_t             in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output swfrm_pkg::out_word_t            out_word_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swfrm_pkg::PADDR_W-1:0]   paddr,
  input  logic [swfrm_pkg::PDATA_W-1:0]   pwdata,
  output logic [swfrm_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import swfrm_pkg::*;

  localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned OCC_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(HISTORY_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  logic [1:0]       state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic [WIN_W-1:0] window_q;
  logic [FPS_W-1:0] run_min_q, run_min_d, run_max_q, run_max_d;
  logic [SUM_W-1:0] run_sum_q, run_sum_d;
  logic [CNT_W-1:0] run_count_q, run_count_d;
  logic             kind_q, kind_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;
  logic [TS_W-1:0]  now_q;
  logic [IDX_W-1:0] idx_q;
  logic [AVG_W-1:0] avg_q, avg_d;

  logic             in_fire, out_free, out_load;
  logic             ram_we;
  logic [PTR_W-1:0] ram_raddr;
  logic [TS_W-1:0]  ram_rdata;
  logic [TS_W:0]    diff;
  logic             expire;
  logic [31:0]      occ_ext;
  logic [FPS_W-1:0] fps;
  logic [SUM_W:0]   sum_ext;
  logic             full;
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_quo;
  logic             cfg_wr;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_WINDOW) ? PDATA_W'(window_q) : '0;

  // Handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Age of the oldest entry; borrow means it lies in the future
  assign diff   = {1'b0, now_q} - {1'b0, ram_rdata};
  assign expire = (occ_q > OCC_W'(1)) && !diff[TS_W] && (diff[TS_W-1:0] >= TS_W'(window_q));

  // Rate saturates at the field range
  assign occ_ext = 32'(occ_q);
  assign fps     = (occ_ext > 32'(FPS_MAX)) ? FPS_MAX : occ_ext[FPS_W-1:0];
  assign sum_ext = {1'b0, run_sum_q} + (SUM_W + 1)'(fps);
  assign full    = (occ_q == OCC_FULL);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    last_d      = last_q;
    kind_d      = kind_q;
    avg_d       = avg_q;
    run_min_d   = run_min_q;
    run_max_d   = run_max_q;
    run_sum_d   = run_sum_q;
    run_count_d = run_count_q;
    ram_we      = 1'b0;
    ram_raddr   = tail_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_word_i.cmd == CMD_REPORT) begin
            kind_d = KIND_REPORT;
            if (run_count_q != '0) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end else begin
              state_d = ST_FIN;
            end
          end else if (in_word_i.frame_index > last_q) begin
            // Write at head; a full ring drops its oldest entry first.
            // The read below never hits the slot written now while it matters.
            kind_d    = KIND_RATE;
            last_d    = in_word_i.frame_index;
            ram_we    = 1'b1;
            head_d    = next_slot(head_q);
            tail_d    = full ? next_slot(tail_q) : tail_q;
            occ_d     = full ? occ_q : occ_q + OCC_W'(1);
            ram_raddr = tail_d;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Retire one expired entry a cycle, prefetching the next tail
        if (expire) begin
          tail_d    = next_slot(tail_q);
          occ_d     = occ_q - OCC_W'(1);
          ram_raddr = tail_d;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_d   = (div_quo[DVD_W-1:AVG_W] != '0) ? AVG_MAX : div_quo[AVG_W-1:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (kind_q == KIND_RATE) begin
            if (fps < run_min_q) run_min_d = fps;
            if (fps > run_max_q) run_max_d = fps;
            if (run_count_q < CNT_MAX) begin
              run_count_d = run_count_q + CNT_W'(1);
              run_sum_d   = (sum_ext > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX
                                                              : sum_ext[SUM_W-1:0];
            end
          end else begin
            run_min_d   = FPS_MAX;
            run_max_d   = '0;
            run_sum_d   = '0;
            run_count_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result word
  always_comb begin
    out_d = '0;
    out_d.kind = kind_q;
    if (kind_q == KIND_RATE) begin
      out_d.fps        = fps;
      out_d.frame_echo = idx_q;
    end else if (run_count_q == '0) begin
      out_d.empty_res = 1'b1;
    end else begin
      out_d.avg_fps_q8  = avg_q;
      out_d.min_fps     = run_min_q;
      out_d.max_fps     = run_max_q;
      out_d.batch_count = run_count_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      last_q      <= '0;
      kind_q      <= KIND_RATE;
      window_q    <= WINDOW_RESET;
      run_min_q   <= FPS_MAX;
      run_max_q   <= '0;
      run_sum_q   <= '0;
      run_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      last_q      <= last_d;
      kind_q      <= kind_d;
      run_min_q   <= run_min_d;
      run_max_q   <= run_max_d;
      run_sum_q   <= run_sum_d;
      run_count_q <= run_count_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr && (paddr[2] == REG_WINDOW)) begin
        window_q <= pwdata[WIN_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    avg_q <= avg_d;
    if (in_fire) begin
      now_q <= in_word_i.timestamp_us;
      idx_q <= in_word_i.frame_index;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Timestamp ring
  swfrm_ram #(
    .WIDTH (TS_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (in_word_i.timestamp_us),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Q8 mean of the batch
  swfrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({run_sum_q, 8'b0}),
    .divisor_i  (run_count_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (head_q == tail_q))
    else $error("empty ring with head and tail apart");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (occ_q != '0))
    else $error("ring scan on an empty ring");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the mean step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside the final step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (kind_q == KIND_RATE)) |-> (fps != '0))
    else $error("accepted frame with zero rate");

endmodule
